FILE: hdl/pitch_note_lock_postprocessor_core_macros.svh
// ----------------------------------------------------------------------------
// Pitch note lock post-processor: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef PITCH_NOTE_LOCK_POSTPROCESSOR_CORE_MACROS_SVH
`define PITCH_NOTE_LOCK_POSTPROCESSOR_CORE_MACROS_SVH

// same-cycle implication
`define PNL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pnl assertion failed");

// next-cycle implication
`define PNL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pnl assertion failed");

`endif

FILE: hdl/pnl_pkg.sv
// ----------------------------------------------------------------------------
// Pitch note lock post-processor package
// Types, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pnl_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_MED, S_CHECK, S_LOGN, S_NOTE, S_MUL1, S_MUL2,
        S_EMAF, S_LOGE, S_WAITE, S_CMUL, S_CFIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        L_IDLE, L_NORM, L_SQR
    } t_log_state;

    typedef struct packed {
        logic        start;
        logic [23:0] x;
    } t_log_req;

    typedef struct packed {
        logic               done;
        logic signed [21:0] result;
    } t_log_rsp;

    localparam logic [0:0]  CFG_LOCK_FRAMES = 1'd0;
    localparam logic [0:0]  CFG_EMA_WEIGHT  = 1'd1;
    localparam logic [7:0]  LOCK_FRAMES_RST = 8'd3;
    localparam logic [16:0] EMA_WEIGHT_RST  = 17'd19661;
    localparam logic [16:0] WEIGHT_ONE      = 17'd65536;
    localparam logic signed [7:0] NOTE_NONE = -8'sd1;

    function automatic logic signed [21:0] f_log2_const(input logic [23:0] x);
        int          e;
        int          i;
        logic [63:0] m;
        logic [15:0] frac;
        e = 23;
        while (e > 0 && x[e] == 1'b0) e--;
        m = 64'(x) << (30 - e);
        frac = '0;
        for (i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return 22'((e - 8) * 65536 + int'(frac));
    endfunction

    localparam logic signed [21:0] LOG_REF = f_log2_const(24'd112640);

endpackage

`default_nettype wire

FILE: hdl/pnl_log2.sv
// ----------------------------------------------------------------------------
// Iterative log2
// log2(x/256) in signed Q16: leading-one search one bit per cycle, then
// sixteen squaring steps of the Q1.30 mantissa on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pnl_log2 (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire pnl_pkg::t_log_req i_req,
    output pnl_pkg::t_log_rsp o_rsp
);

    pnl_pkg::t_log_state r_state, n_state;
    logic [23:0] r_x, n_x;
    logic [4:0]  r_e, n_e;
    logic [30:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [61:0] sq;

    assign sq = r_m * r_m;

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_e     = r_e;
        n_m     = r_m;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            pnl_pkg::L_IDLE: begin
                if (i_req.start) begin
                    n_x     = (i_req.x == '0) ? 24'd1 : i_req.x;
                    n_e     = 5'd23;
                    n_state = pnl_pkg::L_NORM;
                end
            end
            pnl_pkg::L_NORM: begin
                if (r_x[23] || r_e == '0) begin
                    n_m     = {r_x, 7'b0};
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = pnl_pkg::L_SQR;
                end else begin
                    n_x = {r_x[22:0], 1'b0};
                    n_e = r_e - 5'd1;
                end
            end
            pnl_pkg::L_SQR: begin
                if (sq[61]) begin
                    n_m    = sq[61:31];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_m    = sq[60:30];
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_done  = 1'b1;
                    n_state = pnl_pkg::L_IDLE;
                end
            end
            default: n_state = pnl_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnl_pkg::L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x    <= n_x;
        r_e    <= n_e;
        r_m    <= n_m;
        r_frac <= n_frac;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = {6'(r_e) - 6'sd8, r_frac};

endmodule

`default_nettype wire

FILE: hdl/pitch_note_lock_postprocessor_core.sv
// ----------------------------------------------------------------------------
// Pitch note lock post-processor
// Median of a frequency ring, note rounding with repeat-count lock, EMA
// smoothing and cents offset, run by a sequencer over a shared multiplier.
//
// Channel    Dir  Fields (lowest bit up)
// s_axis     in   tdata: frequency[23:0], confidence[39:24]
// m_axis     out  tdata: smoothed_frequency[23:0], locked_note[31:24],
//                        cents_offset[47:32]; tuser: valid_res
// cfg        in   index 0 lock_frames, 1 ema_weight
//
// A pitched frame runs the median scan (once the ring is full), the control steps
// and two log2 passes, each a leading-one search, 16 squarings and a return. A
// silent or low-confidence frame skips both log2 passes and goes from its check
// step straight to the output step, with the result marked invalid.
// Ready only in idle; a result may wait in the output register while the next
// frame is taken, and the sequencer holds at its output step until that register
// frees. Synchronous active-low reset, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_note_lock_postprocessor_core #(
    parameter int MEDIAN_DEPTH = 5
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,   // frequency, confidence
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // smoothed_frequency, locked_note, cents_offset
    output logic        o_m_axis_tuser,   // valid_res
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [16:0] i_cfg_wdata
);

    localparam int PW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
    localparam int CW = $clog2(MEDIAN_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(MEDIAN_DEPTH);
    localparam logic [CW-1:0] MID  = CW'(MEDIAN_DEPTH / 2);
    localparam logic [PW-1:0] LAST = PW'(MEDIAN_DEPTH - 1);

    pnl_pkg::t_state r_state, n_state;
    logic [23:0] r_ring [MEDIAN_DEPTH];
    logic [PW-1:0] r_ptr, n_ptr, r_idx, n_idx;
    logic [CW-1:0] r_fill, n_fill;
    logic [23:0] r_med, n_med, r_ema, n_ema;
    logic        r_usable, n_usable;
    logic signed [7:0] r_held, n_held, r_pend, n_pend;
    logic [7:0]  r_cnt, n_cnt, r_lock, n_lock;
    logic [16:0] r_wgt, n_wgt;
    logic signed [22:0] r_diff, n_diff;
    logic signed [42:0] r_prod, n_prod;
    logic [40:0] r_acc, n_acc;
    logic [23:0] r_rfreq, n_rfreq;
    logic signed [15:0] r_rcents, n_rcents;
    logic        r_rvalid, n_rvalid;
    logic [47:0] r_odata, n_odata;
    logic        r_ouser, n_ouser, r_ovalid, n_ovalid;

    pnl_pkg::t_log_req log_req;
    pnl_pkg::t_log_rsp log_rsp;
    logic signed [17:0] mul_a;
    logic signed [24:0] mul_b;
    logic [CW-1:0] less_n, eq_n;
    logic [23:0] cand;
    logic        ring_we;
    logic [16:0] w_sat;

    pnl_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_rsp   (log_rsp)
    );

    assign cand  = r_ring[r_idx];
    assign w_sat = (r_wgt > pnl_pkg::WEIGHT_ONE) ? pnl_pkg::WEIGHT_ONE : r_wgt;

    always_comb begin
        less_n = '0;
        eq_n   = '0;
        for (int j = 0; j < MEDIAN_DEPTH; j++) begin
            if (r_ring[j] < cand)  less_n = less_n + CW'(1);
            if (r_ring[j] == cand) eq_n   = eq_n + CW'(1);
        end
    end

    always_comb begin
        mul_a = $signed({1'b0, w_sat});
        mul_b = $signed({1'b0, r_med});
        case (r_state)
            pnl_pkg::S_MUL2: begin
                mul_a = $signed({1'b0, pnl_pkg::WEIGHT_ONE - w_sat});
                mul_b = $signed({1'b0, r_ema});
            end
            pnl_pkg::S_CMUL: begin
                mul_a = 18'sd12000;
                mul_b = 25'(r_diff);
            end
            default: ;
        endcase
    end

    always_comb begin
        logic signed [27:0] n12;
        logic [27:0]        m12;
        logic [11:0]        r12;
        logic signed [12:0] note_w;
        logic signed [7:0]  note;
        logic [42:0]        mc;
        logic [26:0]        rc;
        logic signed [31:0] cw;
        logic [41:0]        esum;

        n_state  = r_state;
        n_ptr    = r_ptr;
        n_idx    = r_idx;
        n_fill   = r_fill;
        n_med    = r_med;
        n_ema    = r_ema;
        n_usable = r_usable;
        n_held   = r_held;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_lock   = r_lock;
        n_wgt    = r_wgt;
        n_diff   = r_diff;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_rfreq  = r_rfreq;
        n_rcents = r_rcents;
        n_rvalid = r_rvalid;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_ovalid = r_ovalid;
        ring_we  = 1'b0;
        log_req.start = 1'b0;
        log_req.x     = (r_state == pnl_pkg::S_LOGE) ? r_ema : r_med;
        o_s_axis_tready = (r_state == pnl_pkg::S_IDLE);

        n12    = 28'(r_diff) * 28'sd12;
        m12    = n12[27] ? 28'(-n12) : 28'(n12);
        r12    = 12'((m12 + 28'd32768) >> 16);
        note_w = n12[27] ? 13'sd69 - $signed({1'b0, r12}) : 13'sd69 + $signed({1'b0, r12});
        note   = (note_w < 0) ? 8'sd0 : (note_w > 13'sd127) ? 8'sd127 : 8'(note_w);

        mc   = r_prod[42] ? 43'(-r_prod) : 43'(r_prod);
        rc   = 27'((mc + 43'd32768) >> 16);
        cw   = r_prod[42] ? -$signed({5'b0, rc}) : $signed({5'b0, rc});
        cw   = cw - 32'(r_held - 8'sd69) * 32'sd1000;
        esum = 42'(r_acc) + 42'(r_prod[40:0]) + 42'd32768;

        if (r_ovalid && i_m_axis_tready) n_ovalid = 1'b0;
        if (i_cfg_we) begin
            if (i_cfg_index == pnl_pkg::CFG_LOCK_FRAMES) n_lock = i_cfg_wdata[7:0];
            else n_wgt = i_cfg_wdata;
        end

        case (r_state)
            pnl_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    ring_we  = 1'b1;
                    n_ptr    = (r_ptr == LAST) ? '0 : r_ptr + PW'(1);
                    n_fill   = (r_fill == FULL) ? FULL : r_fill + CW'(1);
                    n_med    = i_s_axis_tdata[23:0];
                    n_usable = !i_s_axis_tdata[39] && (i_s_axis_tdata[39:24] != '0);
                    n_idx    = '0;
                    n_state  = (n_fill == FULL) ? pnl_pkg::S_MED : pnl_pkg::S_CHECK;
                end
            end
            pnl_pkg::S_MED: begin
                if (less_n <= MID && (less_n + eq_n) > MID) n_med = cand;
                n_idx = r_idx + PW'(1);
                if (r_idx == LAST) n_state = pnl_pkg::S_CHECK;
            end
            pnl_pkg::S_CHECK: begin
                if (r_med == '0 || !r_usable) begin
                    n_rfreq  = '0;
                    n_rcents = '0;
                    n_rvalid = 1'b0;
                    n_state  = pnl_pkg::S_OUT;
                end else begin
                    log_req.start = 1'b1;
                    n_state = pnl_pkg::S_LOGN;
                end
            end
            pnl_pkg::S_LOGN: begin
                if (log_rsp.done) begin
                    n_diff  = 23'(log_rsp.result) - 23'(pnl_pkg::LOG_REF);
                    n_state = pnl_pkg::S_NOTE;
                end
            end
            pnl_pkg::S_NOTE: begin
                if (note == r_held) begin
                    n_pend = pnl_pkg::NOTE_NONE;
                    n_cnt  = '0;
                end else begin
                    if (note == r_pend) begin
                        if (r_cnt != 8'hFF) n_cnt = r_cnt + 8'd1;
                    end else begin
                        n_pend = note;
                        n_cnt  = 8'd1;
                    end
                    if (n_cnt >= r_lock) begin
                        n_held = n_pend;
                        n_ema  = r_med;
                        n_pend = pnl_pkg::NOTE_NONE;
                        n_cnt  = '0;
                    end
                end
                if (n_held < 0) n_held = note;
                if (n_ema == '0) begin
                    n_ema   = r_med;
                    n_state = pnl_pkg::S_LOGE;
                end else begin
                    n_state = pnl_pkg::S_MUL1;
                end
            end
            pnl_pkg::S_MUL1: begin
                n_prod  = mul_a * mul_b;
                n_state = pnl_pkg::S_MUL2;
            end
            pnl_pkg::S_MUL2: begin
                n_acc   = r_prod[40:0];
                n_prod  = mul_a * mul_b;
                n_state = pnl_pkg::S_EMAF;
            end
            pnl_pkg::S_EMAF: begin
                n_ema   = esum[39:16];
                n_state = pnl_pkg::S_LOGE;
            end
            pnl_pkg::S_LOGE: begin
                n_rfreq  = r_ema;
                n_rvalid = 1'b1;
                if (r_ema == '0 || r_held < 0) begin
                    n_rcents = '0;
                    n_state  = pnl_pkg::S_OUT;
                end else begin
                    log_req.start = 1'b1;
                    n_state = pnl_pkg::S_WAITE;
                end
            end
            pnl_pkg::S_WAITE: begin
                if (log_rsp.done) begin
                    n_diff  = 23'(log_rsp.result) - 23'(pnl_pkg::LOG_REF);
                    n_state = pnl_pkg::S_CMUL;
                end
            end
            pnl_pkg::S_CMUL: begin
                n_prod  = mul_a * mul_b;
                n_state = pnl_pkg::S_CFIN;
            end
            pnl_pkg::S_CFIN: begin
                if (cw > 32'sd24000) n_rcents = 16'sd24000;
                else if (cw < -32'sd24000) n_rcents = -16'sd24000;
                else n_rcents = 16'(cw);
                n_state = pnl_pkg::S_OUT;
            end
            pnl_pkg::S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_odata  = {r_rcents, r_held, r_rfreq};
                    n_ouser  = r_rvalid;
                    n_ovalid = 1'b1;
                    n_state  = pnl_pkg::S_IDLE;
                end
            end
            default: n_state = pnl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pnl_pkg::S_IDLE;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_ema    <= '0;
            r_held   <= pnl_pkg::NOTE_NONE;
            r_pend   <= pnl_pkg::NOTE_NONE;
            r_cnt    <= '0;
            r_lock   <= pnl_pkg::LOCK_FRAMES_RST;
            r_wgt    <= pnl_pkg::EMA_WEIGHT_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_fill   <= n_fill;
            r_ema    <= n_ema;
            r_held   <= n_held;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
            r_lock   <= n_lock;
            r_wgt    <= n_wgt;
            r_ovalid <= n_ovalid;
        end
        r_idx    <= n_idx;
        r_med    <= n_med;
        r_usable <= n_usable;
        r_diff   <= n_diff;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_rfreq  <= n_rfreq;
        r_rcents <= n_rcents;
        r_rvalid <= n_rvalid;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MEDIAN_DEPTH; k++) r_ring[k] <= '0;
        end else if (ring_we) begin
            r_ring[r_ptr] <= i_s_axis_tdata[23:0];
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

`include "pitch_note_lock_postprocessor_core_macros.svh"

    `PNL_ASSERT_NEXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `PNL_ASSERT_SAME(a_invalid_zero, o_m_axis_tvalid && !o_m_axis_tuser,
                     o_m_axis_tdata[23:0] == '0 && o_m_axis_tdata[47:32] == '0)
    `PNL_ASSERT_SAME(a_valid_has_note, o_m_axis_tvalid && o_m_axis_tuser, !o_m_axis_tdata[31])
    `PNL_ASSERT_SAME(a_log_only_busy, log_rsp.done,
                     r_state == pnl_pkg::S_LOGN || r_state == pnl_pkg::S_WAITE)

endmodule

`default_nettype wire
